// ===== rtl/hid_pkg.sv =====
// ----------------------------------------------------------------------------
// hid_pkg: shared definitions for the 2-D Hilbert index pipeline
// Holds the orientation table type, its starting value and pipeline sizing.
// ----------------------------------------------------------------------------
package hid_pkg;

	// Default coordinate width and the fixed width of each stream field.
	localparam int COORD_BITS_DEF  = 64;
	localparam int FIELD_BITS      = 64;
	localparam int TDATA_BITS      = 2 * FIELD_BITS;

	// Number of coordinate bit pairs resolved in one pipeline stage.
	localparam int STEPS_PER_STAGE = 8;

	// 2x2 orientation table, indexed [row bit][col bit].
	typedef struct packed {
		logic t00;
		logic t01;
		logic t10;
		logic t11;
	} orient_t;

	localparam orient_t ORIENT_INIT = '{t00: 1'b0, t01: 1'b0, t10: 1'b1, t11: 1'b1};

endpackage

// ===== rtl/hid_stage.sv =====
// ----------------------------------------------------------------------------
// hid_stage: one pipeline stage of the Hilbert index conversion
// Resolves a run of coordinate bit pairs, from TOP_BIT downward, and holds
// the updated orientation table and partial index in its output register.
// ----------------------------------------------------------------------------
module hid_stage #(
	parameter int COORD_BITS = hid_pkg::COORD_BITS_DEF,
	parameter int TOP_BIT    = COORD_BITS - 1,
	parameter int NSTEPS     = hid_pkg::STEPS_PER_STAGE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [COORD_BITS-1:0]     in_row,
	input  logic [COORD_BITS-1:0]     in_col,
	input  hid_pkg::orient_t          in_orient,
	input  logic [2*COORD_BITS-1:0]   in_index,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [COORD_BITS-1:0]     out_row,
	output logic [COORD_BITS-1:0]     out_col,
	output hid_pkg::orient_t          out_orient,
	output logic [2*COORD_BITS-1:0]   out_index
);
	import hid_pkg::*;

	logic                    valid_s;
	logic [COORD_BITS-1:0]   row_s;
	logic [COORD_BITS-1:0]   col_s;
	orient_t                 orient_s;
	logic [2*COORD_BITS-1:0] index_s;

	orient_t                 orient_nxt;
	logic [2*COORD_BITS-1:0] index_nxt;
	logic                    load;

	// Walk the bit pairs of this stage, most significant first.
	always_comb begin
		orient_t o;
		logic    bi;
		logic    bj;
		logic    tb;
		logic    xb;
		logic    tmp;
		o         = in_orient;
		index_nxt = in_index;
		for (int i = 0; i < NSTEPS; i++) begin
			bi = in_row[TOP_BIT - i];
			bj = in_col[TOP_BIT - i];
			xb = bi ^ bj;
			case ({bi, bj})
				2'b00:   tb = o.t00;
				2'b01:   tb = o.t01;
				2'b10:   tb = o.t10;
				default: tb = o.t11;
			endcase
			index_nxt[2*(TOP_BIT - i) + 1] = tb;
			index_nxt[2*(TOP_BIT - i)]     = xb;
			// Equal table and XOR bits swap two table entries on a diagonal chosen by the XOR bit.
			if (tb == xb) begin
				if (!xb) begin
					tmp   = o.t10;
					o.t10 = o.t01;
					o.t01 = tmp;
				end else begin
					tmp   = o.t00;
					o.t00 = o.t11;
					o.t11 = tmp;
				end
			end
		end
		orient_nxt = o;
	end

	// The stage takes a beat when it is empty or its contents move on.
	assign in_ready = !valid_s || out_ready;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	// Payload register; it needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			row_s    <= in_row;
			col_s    <= in_col;
			orient_s <= orient_nxt;
			index_s  <= index_nxt;
		end
	end

	assign out_valid  = valid_s;
	assign out_row    = row_s;
	assign out_col    = col_s;
	assign out_orient = orient_s;
	assign out_index  = index_s;

endmodule

// ===== rtl/hilbert_index_2d.sv =====
// ----------------------------------------------------------------------------
// hilbert_index_2d: streaming 2-D Hilbert curve index converter
// Maps a (row, col) coordinate pair to its position along a Hilbert curve.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one coordinate pair per beat: row in the low
//   64 bits of s_tdata, col in the high 64 bits. Only the low COORD_BITS bits
//   of each coordinate are used. The master stream returns one beat per input
//   beat, in order: index_high in the low 64 bits of m_tdata, index_low in
//   the high 64 bits, each holding COORD_BITS bits right-aligned, zero above.
//   Each beat passes through a chain of registered pipeline stages, each
//   resolving up to eight coordinate bit pairs. Throughput is one beat per
//   cycle while m_tready is high. Nothing is kept between beats.
//   Reset empties every stage; s_tready is high right after reset.
//   When m_tready is low the pipeline keeps filling bubbles and then holds,
//   with no beat lost or repeated; s_tready drops once every stage is full.
// ----------------------------------------------------------------------------
module hilbert_index_2d #(
	parameter int COORD_BITS = hid_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [hid_pkg::TDATA_BITS-1:0] s_tdata,  // row, col
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [hid_pkg::TDATA_BITS-1:0] m_tdata   // index_high, index_low
);
	import hid_pkg::*;

	localparam int NUM_STAGES = (COORD_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	logic                    valid_w [NUM_STAGES+1];
	logic                    ready_w [NUM_STAGES+1];
	logic [COORD_BITS-1:0]   row_w   [NUM_STAGES+1];
	logic [COORD_BITS-1:0]   col_w   [NUM_STAGES+1];
	orient_t                 orient_w[NUM_STAGES+1];
	logic [2*COORD_BITS-1:0] index_w [NUM_STAGES+1];

	// Pipeline entry: unpack the beat and start from the initial table.
	assign valid_w[0]  = s_tvalid;
	assign s_tready    = ready_w[0];
	assign row_w[0]    = s_tdata[COORD_BITS-1:0];
	assign col_w[0]    = s_tdata[FIELD_BITS +: COORD_BITS];
	assign orient_w[0] = ORIENT_INIT;
	assign index_w[0]  = '0;

	// Stage chain, each covering a run of bit pairs from the top down.
	for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
		localparam int TOP   = COORD_BITS - 1 - s * STEPS_PER_STAGE;
		localparam int STEPS = (TOP + 1 < STEPS_PER_STAGE) ? TOP + 1 : STEPS_PER_STAGE;

		hid_stage #(
			.COORD_BITS (COORD_BITS),
			.TOP_BIT    (TOP),
			.NSTEPS     (STEPS)
		) u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (valid_w[s]),
			.in_ready   (ready_w[s]),
			.in_row     (row_w[s]),
			.in_col     (col_w[s]),
			.in_orient  (orient_w[s]),
			.in_index   (index_w[s]),
			.out_valid  (valid_w[s+1]),
			.out_ready  (ready_w[s+1]),
			.out_row    (row_w[s+1]),
			.out_col    (col_w[s+1]),
			.out_orient (orient_w[s+1]),
			.out_index  (index_w[s+1])
		);
	end

	// The last stage register drives the master stream directly.
	assign m_tvalid            = valid_w[NUM_STAGES];
	assign ready_w[NUM_STAGES] = m_tready;
	assign m_tdata[FIELD_BITS-1:0] =
		FIELD_BITS'(index_w[NUM_STAGES][2*COORD_BITS-1:COORD_BITS]);
	assign m_tdata[TDATA_BITS-1:FIELD_BITS] =
		FIELD_BITS'(index_w[NUM_STAGES][COORD_BITS-1:0]);

endmodule
